// ===== rtl/core/led_matrix_mode_display_core_assert.svh =====
// Assertion macros for the LED matrix mode display core.
`ifndef LED_MATRIX_MODE_DISPLAY_CORE_ASSERT_SVH
`define LED_MATRIX_MODE_DISPLAY_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LMMD_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LMMD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

// ===== rtl/core/lmmd_pkg.sv =====
// Types, codes and constant tables shared by the LED matrix mode display core.
package lmmd_pkg;

	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;
	localparam int DelayW   = 16;
	localparam int TimeW    = 32;

	// The scroll window covers eight glyphs of six columns each.
	localparam int WindowCols = 48;
	localparam logic [5:0] PosLast = 6'(WindowCols - 1);

	typedef enum logic [2:0] {
		MODE_NORMAL    = 3'd0,
		MODE_SCROLL    = 3'd1,
		MODE_ERROR     = 3'd2,
		MODE_CLOSED    = 3'd3,
		MODE_EMERGENCY = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_FACE   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_BLINK  = 2'd2
	} burst_kind_t;

	typedef enum logic {
		REG_SCROLL_DELAY = 1'b0,
		REG_BLINK_DELAY  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [TimeW-1:0] now_ms;
	} cmd_word_t;

	typedef struct packed {
		logic       is_column;
		logic [2:0] line_index;
		logic [7:0] pattern;
		logic       last;
	} led_word_t;

	localparam logic [7:0] FaceRows [8] = '{
		8'h3C, 8'h42, 8'hA5, 8'h81, 8'hA5, 8'h99, 8'h42, 8'h3C
	};

	// Font columns laid out along the window; every sixth column is the blank gap.
	localparam logic [7:0] WindowRom [WindowCols] = '{
		8'h62, 8'h91, 8'h91, 8'h91, 8'h4E, 8'h00,
		8'hFF, 8'h88, 8'h88, 8'h88, 8'h70, 8'h00,
		8'hFF, 8'h89, 8'h89, 8'h89, 8'h81, 8'h00,
		8'h7E, 8'h81, 8'h81, 8'h81, 8'h42, 8'h00,
		8'h00, 8'h81, 8'hFF, 8'h81, 8'h00, 8'h00,
		8'h7F, 8'h88, 8'h88, 8'h88, 8'h7F, 8'h00,
		8'hFF, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

endpackage

// ===== rtl/core/led_matrix_mode_display_core.sv =====
// LED matrix mode display core: turns service calls into bursts of matrix row/column writes.
// A writing call passes the call register, burst generator and output register, one word
// per cycle unless stalled; it is taken once the single eight-word burst generator is free.
// Calls that write nothing are taken at one per cycle while no burst is running.
// Reset clears the scroll position, blink flag and timestamps, and loads delays of 150 and 500 ms.
`include "led_matrix_mode_display_core_assert.svh"

module led_matrix_mode_display_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  lmmd_pkg::cmd_word_t           cmd,
	output logic                          led_valid,
	input  logic                          led_stall,
	output lmmd_pkg::led_word_t           led,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmmd_pkg::ApbAddrW-1:0] paddr,
	input  logic [lmmd_pkg::ApbDataW-1:0] pwdata,
	output logic [lmmd_pkg::ApbDataW-1:0] prdata,
	output logic                          pready
);
	import lmmd_pkg::*;

	logic [DelayW-1:0] scroll_delay_q;
	logic [DelayW-1:0] blink_delay_q;
	logic [5:0]        scroll_pos_q;
	logic [TimeW-1:0]  last_scroll_q;
	logic [TimeW-1:0]  last_blink_q;
	logic              blink_on_q;

	logic              cmd_valid_s1;
	cmd_word_t         cmd_s1;

	logic              gen_active_q;
	burst_kind_t       gen_kind_q;
	logic [5:0]        gen_base_q;
	logic              gen_blink_q;
	logic [2:0]        gen_cnt_q;

	logic              led_valid_q;
	led_word_t         led_q;

	logic              cfg_write;
	cfg_reg_t          cfg_sel;
	logic              led_load;
	logic              gen_step;
	logic              gen_free;
	logic              take_s1;
	logic              scroll_elapsed;
	logic              blink_elapsed;
	logic              emit;
	burst_kind_t       emit_kind;
	logic              scroll_step;
	logic              blink_step;
	logic [5:0]        pos_next;
	logic [5:0]        src_sum;
	logic [5:0]        src;
	led_word_t         gen_word;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_sel   = cfg_reg_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_sel)
			REG_SCROLL_DELAY: prdata = {{(ApbDataW-DelayW){1'b0}}, scroll_delay_q};
			REG_BLINK_DELAY:  prdata = {{(ApbDataW-DelayW){1'b0}}, blink_delay_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_delay_q <= 16'd150;
			blink_delay_q  <= 16'd500;
		end else if (cfg_write) begin
			unique case (cfg_sel)
				REG_SCROLL_DELAY: scroll_delay_q <= pwdata[DelayW-1:0];
				REG_BLINK_DELAY:  blink_delay_q  <= pwdata[DelayW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the generator can take a new call once its last word moves to the output.
	assign led_load  = !led_valid_q || !led_stall;
	assign gen_step  = gen_active_q && led_load;
	assign gen_free  = !gen_active_q || (gen_step && gen_cnt_q == 3'd7);
	assign take_s1   = cmd_valid_s1 && gen_free;
	assign cmd_stall = cmd_valid_s1 && !gen_free;

	// Elapsed checks use the wrapped 32-bit difference.
	assign scroll_elapsed = (cmd_s1.now_ms - last_scroll_q) >= {16'd0, scroll_delay_q};
	assign blink_elapsed  = (cmd_s1.now_ms - last_blink_q) >= {16'd0, blink_delay_q};
	assign pos_next       = (scroll_pos_q == PosLast) ? 6'd0 : scroll_pos_q + 6'd1;

	always_comb begin
		emit        = 1'b0;
		emit_kind   = KIND_FACE;
		scroll_step = 1'b0;
		blink_step  = 1'b0;
		unique case (mode_t'(cmd_s1.mode))
			MODE_NORMAL: begin
				emit = 1'b1;
			end
			MODE_SCROLL: begin
				if (scroll_elapsed) begin
					emit        = 1'b1;
					emit_kind   = KIND_SCROLL;
					scroll_step = 1'b1;
				end
			end
			MODE_ERROR: begin
				if (blink_elapsed) begin
					emit       = 1'b1;
					emit_kind  = KIND_BLINK;
					blink_step = 1'b1;
				end
			end
			MODE_CLOSED, MODE_EMERGENCY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_valid_s1 || take_s1) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_pos_q  <= 6'd0;
			last_scroll_q <= '0;
			blink_on_q    <= 1'b0;
			last_blink_q  <= '0;
		end else if (take_s1) begin
			if (scroll_step) begin
				scroll_pos_q  <= pos_next;
				last_scroll_q <= cmd_s1.now_ms;
			end
			if (blink_step) begin
				blink_on_q   <= !blink_on_q;
				last_blink_q <= cmd_s1.now_ms;
			end
		end
	end

	// Burst generator: eight words per writing call.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_active_q <= 1'b0;
			gen_cnt_q    <= 3'd0;
		end else if (take_s1 && emit) begin
			gen_active_q <= 1'b1;
			gen_cnt_q    <= 3'd0;
		end else if (gen_step) begin
			gen_cnt_q <= gen_cnt_q + 3'd1;
			if (gen_cnt_q == 3'd7) begin
				gen_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && emit) begin
			gen_kind_q  <= emit_kind;
			gen_base_q  <= scroll_pos_q;
			gen_blink_q <= !blink_on_q;
		end
	end

	assign src_sum = gen_base_q + {3'd0, gen_cnt_q};
	assign src     = (src_sum > PosLast) ? src_sum - 6'(WindowCols) : src_sum;

	always_comb begin
		gen_word.line_index = gen_cnt_q;
		gen_word.last       = (gen_cnt_q == 3'd7);
		unique case (gen_kind_q)
			KIND_FACE: begin
				gen_word.is_column = 1'b0;
				gen_word.pattern   = FaceRows[gen_cnt_q];
			end
			KIND_SCROLL: begin
				gen_word.is_column = 1'b1;
				gen_word.pattern   = WindowRom[src];
			end
			KIND_BLINK: begin
				gen_word.is_column = 1'b0;
				gen_word.pattern   = {8{gen_blink_q}};
			end
			default: begin
				gen_word.is_column = 1'b0;
				gen_word.pattern   = 8'h00;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_valid_q <= 1'b0;
		end else if (led_load) begin
			led_valid_q <= gen_active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_step) begin
			led_q <= gen_word;
		end
	end

	assign led_valid = led_valid_q;
	assign led       = led_q;

	`LMMD_ASSERT_IMPLY(a_idle_count_zero, !gen_active_q, gen_cnt_q == 3'd0, "idle generator holds a count")
	`LMMD_ASSERT_IMPLY(a_pos_in_window, 1'b1, scroll_pos_q <= PosLast, "scroll position outside window")
	`LMMD_ASSERT_IMPLY(a_last_on_eighth, led_valid_q, led_q.last == (led_q.line_index == 3'd7), "last flag misplaced")
	`LMMD_ASSERT_NEXT(a_held_call_kept, cmd_valid_s1 && !gen_free, cmd_valid_s1 && $stable(cmd_s1), "held call lost")
	`LMMD_ASSERT_NEXT(a_burst_starts, take_s1 && emit, gen_active_q && gen_cnt_q == 3'd0, "burst did not start")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the LED matrix mode display core: random calls, delay setups, stalls.
module tb_top;
	import lmmd_pkg::*;

	localparam int QuietLimit = 4000;
	localparam int Settle     = 16;
	localparam int ViewCols   = 48;
	localparam int GlyphPitch = 6;

	localparam logic [7:0] face_bits [8] = '{
		8'h3C, 8'h42, 8'hA5, 8'h81, 8'hA5, 8'h99, 8'h42, 8'h3C
	};
	localparam logic [7:0] glyph_cols [8][5] = '{
		'{8'h62, 8'h91, 8'h91, 8'h91, 8'h4E},
		'{8'hFF, 8'h88, 8'h88, 8'h88, 8'h70},
		'{8'hFF, 8'h89, 8'h89, 8'h89, 8'h81},
		'{8'h7E, 8'h81, 8'h81, 8'h81, 8'h42},
		'{8'h00, 8'h81, 8'hFF, 8'h81, 8'h00},
		'{8'h7F, 8'h88, 8'h88, 8'h88, 8'h7F},
		'{8'hFF, 8'h01, 8'h01, 8'h01, 8'h01},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	cmd_word_t           cmd       = '0;
	logic                led_valid;
	logic                led_stall = 1'b0;
	led_word_t           led;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ApbAddrW-1:0] paddr     = '0;
	logic [ApbDataW-1:0] pwdata    = '0;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	led_matrix_mode_display_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.led       (led),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mirror of the display state, advanced once per accepted call.
	logic [5:0]        scroll_pos   = '0;
	logic [31:0]       scroll_stamp = '0;
	logic              blink_lit    = 1'b0;
	logic [31:0]       blink_stamp  = '0;
	logic [DelayW-1:0] scroll_gap   = 16'd150;
	logic [DelayW-1:0] blink_gap    = 16'd500;

	cmd_word_t   pending_calls [$];
	led_word_t   display_writes [$];
	int unsigned calls_queued   = 0;
	int unsigned calls_taken    = 0;
	int unsigned words_seen     = 0;
	int unsigned face_bursts    = 0;
	int unsigned scroll_steps   = 0;
	int unsigned blink_flips    = 0;
	int unsigned silent_calls   = 0;
	int unsigned mismatches     = 0;
	int unsigned quiet_cycles   = 0;
	logic [31:0] wall_ms        = '0;
	bit          idle_on        = 1'b1;
	bit          hold_arm       = 1'b0;
	bit          hold_done      = 1'b0;
	int unsigned hold_left      = 0;
	bit          offer;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic render_call(input cmd_word_t c);
		logic [31:0] elapsed;
		led_word_t   w;
		int          src;
		bit          fires;
		fires = 1'b0;
		case (c.mode)
			MODE_NORMAL: begin
				fires = 1'b1;
				face_bursts++;
			end
			MODE_SCROLL: begin
				elapsed = c.now_ms - scroll_stamp;
				if (elapsed >= 32'(scroll_gap)) begin
					fires = 1'b1;
					scroll_stamp = c.now_ms;
					scroll_steps++;
				end
			end
			MODE_ERROR: begin
				elapsed = c.now_ms - blink_stamp;
				if (elapsed >= 32'(blink_gap)) begin
					fires = 1'b1;
					blink_stamp = c.now_ms;
					blink_lit = ~blink_lit;
					blink_flips++;
				end
			end
			default: ;
		endcase
		if (!fires) begin
			silent_calls++;
			return;
		end
		for (int k = 0; k < 8; k++) begin
			w.is_column  = (c.mode == MODE_SCROLL);
			w.line_index = 3'(k);
			w.last       = (k == 7);
			if (c.mode == MODE_NORMAL) begin
				w.pattern = face_bits[k];
			end else if (c.mode == MODE_SCROLL) begin
				src = (int'(scroll_pos) + k) % ViewCols;
				// The sixth column of every glyph is the blank gap.
				w.pattern = (src % GlyphPitch < 5) ? glyph_cols[src / GlyphPitch][src % GlyphPitch]
				                                   : 8'h00;
			end else begin
				w.pattern = blink_lit ? 8'hFF : 8'h00;
			end
			display_writes.push_back(w);
		end
		if (c.mode == MODE_SCROLL)
			scroll_pos = 6'((int'(scroll_pos) + 1) % ViewCols);
	endtask

	// Call driver: holds a stalled word, otherwise offers the next pending call.
	always @(posedge clk) begin
		if (arst_n) begin
			offer = cmd_valid;
			if (cmd_valid && !cmd_stall) begin
				calls_taken++;
				offer = 1'b0;
			end
			if (!offer && pending_calls.size() != 0 && !(idle_on && $urandom_range(0, 99) < 20)) begin
				cmd <= pending_calls.pop_front();
				offer = 1'b1;
			end
			cmd_valid <= offer;
		end
	end

	// Receiver stall, with one long hold-off once armed so the core backs up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				led_stall <= 1'b1;
			end else if (hold_arm && !hold_done && led_valid) begin
				hold_left = 199;
				hold_done = 1'b1;
				led_stall <= 1'b1;
			end else begin
				led_stall <= idle_on && ($urandom_range(0, 99) < 20);
			end
		end
	end

	// Monitor: predict on accepted calls, compare accepted matrix writes in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				render_call(cmd);
			if (led_valid && !led_stall) begin
				words_seen++;
				if (display_writes.size() == 0) begin
					report($sformatf("word col=%0d idx=%0d pat=%02h last=%0d with none expected",
						led.is_column, led.line_index, led.pattern, led.last));
				end else begin
					if (led !== display_writes[0])
						report($sformatf("want col=%0d idx=%0d pat=%02h last=%0d, got col=%0d idx=%0d pat=%02h last=%0d",
							display_writes[0].is_column, display_writes[0].line_index,
							display_writes[0].pattern, display_writes[0].last,
							led.is_column, led.line_index, led.pattern, led.last));
					void'(display_writes.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (led_valid && !led_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("timeout after %0d cycles with no progress", QuietLimit);
				$display("led_matrix_mode_display_core regression: fail");
				$finish;
			end
		end
	end

	task automatic queue_call(input logic [2:0] mode, input logic [31:0] now);
		cmd_word_t c;
		c.mode   = mode;
		c.now_ms = now;
		pending_calls.push_back(c);
		calls_queued++;
	endtask

	task automatic random_calls(input int count, input int unsigned step_max);
		int unsigned pick;
		logic [2:0]  mode;
		repeat (count) begin
			pick = $urandom_range(0, 19);
			if (pick < 4)
				mode = MODE_NORMAL;
			else if (pick < 11)
				mode = MODE_SCROLL;
			else if (pick < 17)
				mode = MODE_ERROR;
			else if (pick == 17)
				mode = MODE_CLOSED;
			else if (pick == 18)
				mode = MODE_EMERGENCY;
			else
				mode = 3'($urandom_range(int'(MODE_EMERGENCY) + 1, 7));
			if ($urandom_range(0, 19) == 0)
				wall_ms = $urandom();
			else
				wall_ms = wall_ms + $urandom_range(0, step_max);
			queue_call(mode, wall_ms);
		end
	endtask

	// Waits for every call and word to drain, then lets the core go quiet.
	task automatic settle();
		do @(negedge clk);
		while (calls_taken != calls_queued || display_writes.size() != 0);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic program_delay(input cfg_reg_t r, input logic [DelayW-1:0] value);
		logic [ApbAddrW-1:0] addr;
		logic [ApbDataW-1:0] readback;
		addr = ApbAddrW'(4 * int'(r));
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		// Upper bits are junk; only the low sixteen are held.
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (r == REG_SCROLL_DELAY)
			scroll_gap = value;
		else
			blink_gap = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== ApbDataW'(value))
			report($sformatf("register %s read %08h, want %08h", r.name(), readback, value));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Delay thresholds, 32-bit wrap of the elapsed time, idle and unused modes.
		queue_call(MODE_NORMAL, 32'd0);
		queue_call(MODE_SCROLL, 32'd0);
		queue_call(MODE_SCROLL, 32'd149);
		queue_call(MODE_SCROLL, 32'd150);
		queue_call(MODE_SCROLL, 32'd299);
		queue_call(MODE_SCROLL, 32'd300);
		queue_call(MODE_ERROR, 32'd499);
		queue_call(MODE_ERROR, 32'd500);
		queue_call(MODE_ERROR, 32'd999);
		queue_call(MODE_ERROR, 32'd1000);
		queue_call(MODE_CLOSED, 32'd1000);
		queue_call(MODE_EMERGENCY, 32'd1000);
		for (int m = int'(MODE_EMERGENCY) + 1; m < 8; m++)
			queue_call(3'(m), 32'hFFFF_FFFF);
		queue_call(MODE_SCROLL, 32'hFFFF_FFFF);
		queue_call(MODE_SCROLL, 32'd5);
		queue_call(MODE_SCROLL, 32'd149);
		queue_call(MODE_ERROR, 32'hFFFF_FFFF);
		queue_call(MODE_NORMAL, 32'hFFFF_FFFF);
		queue_call(MODE_ERROR, 32'd499);
		settle();

		// Zero delays: every scroll and blink call steps.
		program_delay(REG_SCROLL_DELAY, 16'd0);
		program_delay(REG_BLINK_DELAY, 16'd0);
		idle_on = 1'b0;
		wall_ms = 32'hFFFF_FF00;
		random_calls(100, 20);
		settle();
		idle_on = 1'b1;

		program_delay(REG_SCROLL_DELAY, 16'hFFFF);
		program_delay(REG_BLINK_DELAY, 16'hFFFF);
		random_calls(60, 40000);
		settle();

		program_delay(REG_SCROLL_DELAY, DelayW'($urandom_range(1, 400)));
		program_delay(REG_BLINK_DELAY, DelayW'($urandom_range(1, 900)));
		hold_arm = 1'b1;
		random_calls(130, 600);
		settle();

		$display("%0d calls taken, %0d words checked: %0d face bursts, %0d scroll steps,",
			calls_taken, words_seen, face_bursts, scroll_steps);
		$display("%0d blink toggles, %0d calls with no writes, %0d mismatches",
			blink_flips, silent_calls, mismatches);
		if (mismatches == 0 && display_writes.size() == 0)
			$display("led_matrix_mode_display_core regression: pass");
		else
			$display("led_matrix_mode_display_core regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lmmd_pkg.sv
rtl/core/led_matrix_mode_display_core.sv
bench/tb_top.sv
